/* hdl/ofs_pkg.sv */
// Shared types and constants for the OLED page framebuffer streamer.
package ofs_pkg;

  // Bus bytes of the controller protocol.
  localparam logic [7:0] DEV_ADDR   = 8'h78;
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COL_START   = 2'd0;
  localparam logic [1:0] CFG_FIRST_PAGE  = 2'd1;
  localparam logic [1:0] CFG_PAGE_COUNT  = 2'd2;

  localparam logic [3:0] PAGE_COUNT_RESET = 4'd8;

  // Byte positions inside one bus transaction.
  localparam logic [3:0] POS_ADDR      = 4'd0;
  localparam logic [3:0] POS_CTRL      = 4'd1;
  localparam logic [3:0] POS_CMD       = 4'd2;
  localparam logic [3:0] POS_DATA0     = 4'd2;
  localparam logic [3:0] POS_DATA_LAST = 4'd9;

  // Transaction currently being sent by the back end.
  typedef enum logic [1:0] {
    FRAME_COL_LO,
    FRAME_COL_HI,
    FRAME_PAGE,
    FRAME_DATA
  } frame_t;

  // One classified column group waiting to go out on the bus.
  typedef struct packed {
    logic [7:0][7:0] cols;
    logic            header;
    logic [2:0]      page;
    logic [3:0]      offset;
  } q_entry_t;

endpackage

/* hdl/ofs_front.sv */
// Front end: configuration, page/group tracking, transpose and queue push.
module ofs_front import ofs_pkg::*; #(
  parameter int COLUMN_GROUPS = 16,
  parameter int DISPLAY_PAGES = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0][7:0] rows,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [3:0]      cfg_data,
  input  logic            full,
  output logic            push,
  output q_entry_t        entry
);

  localparam int GW = (COLUMN_GROUPS > 1) ? $clog2(COLUMN_GROUPS) : 1;
  localparam logic [GW-1:0] LAST_GROUP = GW'(COLUMN_GROUPS - 1);
  localparam logic [3:0] PAGE_LIMIT = 4'(DISPLAY_PAGES);

  logic [3:0]    col_start;
  logic [2:0]    first_page;
  logic [3:0]    page_count;
  logic [GW-1:0] group_index;
  logic [2:0]    current_page;
  logic [3:0]    pages_left;

  logic [GW-1:0] group_index_next;
  logic [2:0]    current_page_next;
  logic [3:0]    pages_left_next;
  logic [3:0]    page_after;
  logic [3:0]    pages_dec;
  logic          page_start;
  logic          drop;
  logic          accept;

  assign in_ready   = !full;
  assign accept     = in_valid && in_ready;
  assign page_start = (group_index == '0);
  // At a page start with no pages left, or past the last display page, the beat is swallowed.
  assign drop = page_start && ((pages_left == 4'd0) || ({1'b0, current_page} >= PAGE_LIMIT));
  assign push = accept && !drop;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) begin
        entry.cols[c][r] = rows[r][7-c];
      end
    end
    entry.header = page_start;
    entry.page   = current_page;
    entry.offset = col_start;
  end

  assign page_after = {1'b0, current_page} + 4'd1;
  assign pages_dec  = pages_left - 4'd1;

  always_comb begin
    group_index_next  = group_index + GW'(1);
    current_page_next = current_page;
    pages_left_next   = pages_left;
    if (group_index == LAST_GROUP) begin
      group_index_next = '0;
      if ((pages_dec == 4'd0) || (page_after >= PAGE_LIMIT)) begin
        current_page_next = first_page;
        pages_left_next   = page_count;
      end else begin
        current_page_next = page_after[2:0];
        pages_left_next   = pages_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_start     <= 4'd0;
      first_page    <= 3'd0;
      page_count    <= PAGE_COUNT_RESET;
      group_index   <= '0;
      current_page  <= 3'd0;
      pages_left    <= PAGE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COL_START: begin
          col_start     <= cfg_data;
          group_index   <= '0;
          current_page  <= first_page;
          pages_left    <= page_count;
        end
        CFG_FIRST_PAGE: begin
          first_page   <= cfg_data[2:0];
          group_index  <= '0;
          current_page <= cfg_data[2:0];
          pages_left   <= page_count;
        end
        CFG_PAGE_COUNT: begin
          page_count   <= cfg_data;
          group_index  <= '0;
          current_page <= first_page;
          pages_left   <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (push) begin
      group_index  <= group_index_next;
      current_page <= current_page_next;
      pages_left   <= pages_left_next;
    end
  end

endmodule

/* hdl/ofs_queue.sv */
// Two-entry queue between the front end and the bus sequencer.
module ofs_queue import ofs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t   slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/ofs_back.sv */
// Back end: walks the queue head's bus transactions, one byte per cycle unless stalled.
module ofs_back import ofs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  q_entry_t   head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bus_byte,
  output logic       start_before,
  output logic       stop_after,
  output logic       last
);

  logic       busy;
  logic       busy_next;
  frame_t     frame;
  frame_t     frame_next;
  frame_t     cur_frame;
  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [3:0] cur_pos;
  logic [2:0] col_sel;
  logic       emit;
  logic       frame_end;
  logic [7:0] byte_c;
  logic       st_c;
  logic       sp_c;
  logic       last_c;

  // An idle sequencer starts the head item right away, so items follow with no gap.
  assign cur_frame = busy ? frame : (head.header ? FRAME_COL_LO : FRAME_DATA);
  assign cur_pos   = busy ? pos : POS_ADDR;
  assign emit      = head_valid && (!out_valid || out_ready);
  assign frame_end = (cur_frame == FRAME_DATA) ? (cur_pos == POS_DATA_LAST)
                                               : (cur_pos == POS_CMD);
  assign col_sel   = 3'(cur_pos - POS_DATA0);

  always_comb begin
    busy_next  = busy;
    frame_next = frame;
    pos_next   = pos;
    pop        = 1'b0;
    if (emit) begin
      if (frame_end) begin
        unique case (cur_frame)
          FRAME_COL_LO: frame_next = FRAME_COL_HI;
          FRAME_COL_HI: frame_next = FRAME_PAGE;
          FRAME_PAGE:   frame_next = FRAME_DATA;
          FRAME_DATA:   frame_next = FRAME_DATA;
        endcase
        pos_next  = POS_ADDR;
        busy_next = (cur_frame != FRAME_DATA);
        pop       = (cur_frame == FRAME_DATA);
      end else begin
        frame_next = cur_frame;
        pos_next   = cur_pos + 4'd1;
        busy_next  = 1'b1;
      end
    end
  end

  always_comb begin
    st_c   = (cur_pos == POS_ADDR);
    sp_c   = frame_end;
    last_c = frame_end && (cur_frame == FRAME_DATA);
    if (cur_pos == POS_ADDR) begin
      byte_c = DEV_ADDR;
    end else if (cur_pos == POS_CTRL) begin
      byte_c = (cur_frame == FRAME_DATA) ? CTRL_DATA : CTRL_CMD;
    end else begin
      unique case (cur_frame)
        FRAME_COL_LO: byte_c = CMD_COL_LO | {4'd0, head.offset};
        FRAME_COL_HI: byte_c = CMD_COL_HI;
        FRAME_PAGE:   byte_c = CMD_PAGE | {5'd0, head.page};
        FRAME_DATA:   byte_c = head.cols[col_sel];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      frame     <= FRAME_DATA;
      pos       <= POS_ADDR;
      out_valid <= 1'b0;
    end else begin
      busy  <= busy_next;
      frame <= frame_next;
      pos   <= pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_byte     <= byte_c;
      start_before <= st_c;
      stop_after   <= sp_c;
      last         <= last_c;
    end
  end

endmodule

/* hdl/oled_page_framebuffer_streamer.sv */
// Top level: turns framebuffer column groups into OLED bus byte beats.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   input    | in_valid / in_ready        | row_byte_0 .. row_byte_7
//   output   | out_valid / out_ready      | bus_byte, start_before, stop_after, last
//   config   | cfg_write (no wait)        | cfg_index, cfg_data
//
// Each queued item yields 10 output beats, or 19 at the first group of a page, one per
// cycle from the byte sequencer unless the output stalls; it sets the sustained rate.
// The input side takes one item per cycle while the two-entry queue has room.
// Reset (synchronous, rst high) empties the queue and loads the register reset values.
// An output stall holds the output register; the front keeps accepting until the queue fills.
module oled_page_framebuffer_streamer import ofs_pkg::*; #(
  parameter int COLUMN_GROUPS = 16,
  parameter int DISPLAY_PAGES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] row_byte_0,
  input  logic [7:0] row_byte_1,
  input  logic [7:0] row_byte_2,
  input  logic [7:0] row_byte_3,
  input  logic [7:0] row_byte_4,
  input  logic [7:0] row_byte_5,
  input  logic [7:0] row_byte_6,
  input  logic [7:0] row_byte_7,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] bus_byte,
  output logic       start_before,
  output logic       stop_after,
  output logic       last,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  logic [7:0][7:0] rows;
  logic            push;
  logic            full;
  q_entry_t        push_entry;
  logic            pop;
  logic            head_valid;
  q_entry_t        head;

  assign rows = {row_byte_7, row_byte_6, row_byte_5, row_byte_4,
                 row_byte_3, row_byte_2, row_byte_1, row_byte_0};

  ofs_front #(
    .COLUMN_GROUPS(COLUMN_GROUPS),
    .DISPLAY_PAGES(DISPLAY_PAGES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rows(rows),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .full(full),
    .push(push),
    .entry(push_entry)
  );

  ofs_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .full(full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  ofs_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bus_byte(bus_byte),
    .start_before(start_before),
    .stop_after(stop_after),
    .last(last)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> stop_after)
    else $error("final beat of an item without stop");
  a_start_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_before) |-> (bus_byte == DEV_ADDR))
    else $error("start condition on a byte other than the device address");
`endif

endmodule
